### hw/rtl/admf_pkg.sv
// ----------------------------------------------------------------------------
// admf_pkg
// Shared types, widths, request codes and the reciprocal table for the
// multichannel-to-mono downmix ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package admf_pkg;

   // Ring geometry (depth is a power of two, pointers wrap naturally)
   localparam int RING_DEPTH = 65536;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // Channel lanes
   localparam int MAX_CHANNELS = 8;
   localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
   localparam int CH_CFG_W     = 4;

   // Sample and arithmetic widths
   localparam int SAMPLE_W    = 18;                               // Q2.15
   localparam int SUM_W       = SAMPLE_W + $clog2(MAX_CHANNELS);  // signed sum
   localparam int MAG_W       = SUM_W;                            // |sum|
   localparam int NUM_W       = MAG_W + 1;                        // 2*|sum| + ch
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 27;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int MONO_W      = 17;                               // Q1.15, +1.0 allowed

   localparam logic [NUM_W-1:0]  Q_ONE_NUM  = NUM_W'(32768);
   localparam logic [MONO_W-1:0] Q_ONE_MONO = MONO_W'(32768);

   // Stream widths
   localparam int REQ_TDATA_W = ((MAX_CHANNELS * SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = MONO_W + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   localparam logic [CH_CFG_W-1:0] CH_CFG_RESET = CH_CFG_W'(1);
   localparam logic [CH_CFG_W-1:0] CH_CFG_MAX   = CH_CFG_W'(MAX_CHANNELS);

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_PULL  = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   // Pipeline step enables from the sequencer
   typedef struct packed {
      logic load;     // capture lane samples
      logic sum_en;   // register adder tree result
      logic mul_en;   // register reciprocal product
   } admf_stage_type;

   // Effective channel count minus one: zero reads as one, above max saturates
   function automatic logic [CH_IDX_W-1:0] chan_index(input logic [CH_CFG_W-1:0] cfg);
      logic [CH_CFG_W-1:0] m1;
      m1 = cfg - CH_CFG_W'(1);
      if (cfg == '0) begin
         return '0;
      end else if (cfg > CH_CFG_MAX) begin
         return CH_IDX_W'(MAX_CHANNELS - 1);
      end else begin
         return m1[CH_IDX_W-1:0];
      end
   endfunction

   // ceil(2^27 / (2*ch)), indexed by ch-1; exact floor division for numerators < 2^22
   function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CH_IDX_W-1:0] idx);
      logic [RECIP_W-1:0] r;
      unique case (idx)
         3'd0:    r = RECIP_W'(67108864);
         3'd1:    r = RECIP_W'(33554432);
         3'd2:    r = RECIP_W'(22369622);
         3'd3:    r = RECIP_W'(16777216);
         3'd4:    r = RECIP_W'(13421773);
         3'd5:    r = RECIP_W'(11184811);
         3'd6:    r = RECIP_W'(9586981);
         3'd7:    r = RECIP_W'(8388608);
         default: r = RECIP_W'(67108864);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/admf_lane.sv
// ----------------------------------------------------------------------------
// admf_lane
// One channel lane: gates an inactive channel to zero, sign-extends the
// Q2.15 sample to sum width and registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module admf_lane
   import admf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic                       active,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SUM_W-1:0]         lane_val
);

   logic signed [SUM_W-1:0] lane_in;
   logic signed [SUM_W-1:0] lane_ff;

   always_comb begin
      if (active) begin
         lane_in = {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      end else begin
         lane_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_val = lane_ff;

endmodule

`default_nettype wire

### hw/rtl/admf_merge.sv
// ----------------------------------------------------------------------------
// admf_merge
// Merges the lane values: adder tree, magnitude and rounding offset, then a
// reciprocal multiply for the divide by channel count, clamp and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module admf_merge
   import admf_pkg::*;
(
   input  wire logic                       clock,
   input  wire admf_stage_type             stage,
   input  wire logic [CH_IDX_W-1:0]        ch_idx,
   input  wire logic signed [SUM_W-1:0]    lane_val [MAX_CHANNELS],
   output logic signed [MONO_W-1:0]        mono
);

   logic signed [SUM_W-1:0] sum_acc;
   logic [MAG_W-1:0]        mag;
   logic [CH_CFG_W-1:0]     ch;
   logic [NUM_W-1:0]        numer_in;
   logic [NUM_W-1:0]        numer_ff;
   logic [RECIP_W-1:0]      recip_ff;
   logic                    neg_ff;
   logic                    neg2_ff;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [NUM_W-1:0]        quot;
   logic [MONO_W-1:0]       quot_sat;

   always_comb begin
      sum_acc = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         sum_acc = sum_acc + lane_val[i];
      end
   end

   // round half away from zero: (2*|sum| + ch) / (2*ch)
   assign mag      = sum_acc[SUM_W-1] ? MAG_W'(-sum_acc) : MAG_W'(sum_acc);
   assign ch       = CH_CFG_W'(ch_idx) + CH_CFG_W'(1);
   assign numer_in = {mag, 1'b0} + NUM_W'(ch);

   always_ff @(posedge clock) begin
      if (stage.sum_en) begin
         numer_ff <= numer_in;
         recip_ff <= recip_lookup(ch_idx);
         neg_ff   <= sum_acc[SUM_W-1];
      end
   end

   assign prod_in = PROD_W'(numer_ff) * PROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      if (stage.mul_en) begin
         prod_ff <= prod_in;
         neg2_ff <= neg_ff;
      end
   end

   assign quot     = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign quot_sat = (quot > Q_ONE_NUM) ? Q_ONE_MONO : quot[MONO_W-1:0];
   assign mono     = neg2_ff ? -$signed(quot_sat) : $signed(quot_sat);

endmodule

`default_nettype wire

### hw/rtl/audio_downmix_ring_fifo.sv
// ----------------------------------------------------------------------------
// audio_downmix_ring_fifo
// Multichannel-to-mono downmix ring FIFO.
//
// Each request transaction carries a request code in req_tuser and eight
// signed Q2.15 channel samples in req_tdata. A push averages the first
// channel_count channels (round half away from zero), clamps to +/-1.0 in
// Q1.15 and stores the sample in a 65536-entry ring unless it is full, in
// which case the frame is discarded and flagged as dropped. A pull returns
// the oldest stored sample, or zero with underrun set on an empty ring. A
// flush empties the ring; code three is a no-op. Every request yields one
// response transaction carrying the current fill level. Each transaction
// goes through the steps accept, lane adder tree, reciprocal multiply, commit,
// set by the four-step sequencer around the shared ring memory; a response
// waiting in the output register holds the commit step. The next request
// is accepted while an earlier response still waits. channel_count may be
// written only while no transaction is in flight. The ring needs no clear
// after reset: only entries written since the last flush are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_downmix_ring_fifo
   import admf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_we,
   input  wire logic [CH_CFG_W-1:0]      csr_wdata,      // channel_count
   // request channel
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,      // chan_sample_0..7, 18 b each
   input  wire logic [1:0]               req_tuser,      // req_type
   // response channel
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,      // mono_out, fill_level, zero pad
   output logic [1:0]                    rsp_tuser       // underrun, dropped
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [CH_CFG_W-1:0] ch_cfg_ff;
   logic [CH_IDX_W-1:0] ch_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_cfg_ff <= CH_CFG_RESET;
      end else if (csr_we) begin
         ch_cfg_ff <= csr_wdata;
      end
   end

   assign ch_idx = chan_index(ch_cfg_ff);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   state_type      state_ff, state_in;
   admf_stage_type stage;
   logic           req_accept;
   logic           out_free;
   logic           commit;
   logic           rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;

   assign stage.load   = req_accept;
   assign stage.sum_en = (state_ff == ST_SUM);
   assign stage.mul_en = (state_ff == ST_MUL);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request code held for the whole transaction
   req_code_type req_type_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_type_ff <= req_code_type'(req_tuser);
      end
   end

   // ---------------------------------------------------------------------
   // Channel lanes and merge
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0]  lane_val [MAX_CHANNELS];
   logic signed [MONO_W-1:0] mix_mono;

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic active;
      assign active = (CH_IDX_W'(c) <= ch_idx);

      admf_lane u_lane (
         .clock    (clock),
         .load     (stage.load),
         .active   (active),
         .sample   ($signed(req_tdata[c*SAMPLE_W +: SAMPLE_W])),
         .lane_val (lane_val[c])
      );
   end

   admf_merge u_merge (
      .clock    (clock),
      .stage    (stage),
      .ch_idx   (ch_idx),
      .lane_val (lane_val),
      .mono     (mix_mono)
   );

   // ---------------------------------------------------------------------
   // Ring memory and pointers
   // ---------------------------------------------------------------------
   logic [MONO_W-1:0] ring_mem [RING_DEPTH];
   logic [MONO_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              ring_full;
   logic              ring_empty;
   logic              do_write;

   assign ring_full  = (count_ff == CNT_W'(RING_DEPTH));
   assign ring_empty = (count_ff == '0);
   assign do_write   = commit && (req_type_ff == REQ_PUSH) && !ring_full;

   // read issued in the multiply step; nothing writes until commit
   always_ff @(posedge clock) begin
      if (stage.mul_en) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_mem[wr_ptr_ff] <= mix_mono;
      end
   end

   // commit: pointer/count update and response payload
   logic [MONO_W-1:0] mono_in;
   logic              underrun_in;
   logic              dropped_in;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      mono_in     = '0;
      underrun_in = 1'b0;
      dropped_in  = 1'b0;
      unique case (req_type_ff)
         REQ_PUSH: begin
            if (ring_full) begin
               dropped_in = 1'b1;
            end else begin
               wr_ptr_in = wr_ptr_ff + PTR_W'(1);
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_PULL: begin
            if (ring_empty) begin
               underrun_in = 1'b1;
            end else begin
               mono_in   = rd_data_ff;
               rd_ptr_in = rd_ptr_ff + PTR_W'(1);
               count_in  = count_ff - CNT_W'(1);
            end
         end
         REQ_FLUSH: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            count_in  = '0;
         end
         REQ_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (commit) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response output register
   // ---------------------------------------------------------------------
   logic [MONO_W-1:0] mono_ff;
   logic              underrun_ff;
   logic              dropped_ff;
   logic [CNT_W-1:0]  fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         mono_ff     <= mono_in;
         underrun_ff <= underrun_in;
         dropped_ff  <= dropped_in;
         fill_ff     <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, fill_ff, mono_ff};
   assign rsp_tuser  = {dropped_ff, underrun_ff};

endmodule

`default_nettype wire

### test/tb_audio_downmix_ring_fifo.sv
// ----------------------------------------------------------------------------
// tb_audio_downmix_ring_fifo
// Self-checking bench for the downmix ring FIFO. Push, pull, flush and no-op
// requests go in over the request stream. A ring tracker mirrors the
// channel averaging, the clamping and the ring bookkeeping. It checks every
// response transaction in order. The random phases stall both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_downmix_ring_fifo;
   import admf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;    // watchdog bound for the whole run
   localparam int DRAIN_CYCLES = 12;        // four-step pipe plus output register
   localparam int REPORT_MAX   = 10;

   typedef logic [REQ_TDATA_W-1:0] frame_type;

   typedef struct packed {
      logic signed [MONO_W-1:0] mono;
      logic                     underrun;
      logic                     dropped;
      logic [CNT_W-1:0]         fill;
   } mono_rsp_type;

   // Mirror of the ring: averages frames, tracks pointers, queues responses
   class downmix_ring_tracker;
      logic signed [MONO_W-1:0] ring [RING_DEPTH];
      int unsigned              wr_ptr;
      int unsigned              rd_ptr;
      int unsigned              held;
      logic [CH_CFG_W-1:0]      chan_cfg;
      mono_rsp_type             awaited_rsp [$];
      int unsigned              mismatches;

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         held       = 0;
         chan_cfg   = CH_CFG_RESET;
         mismatches = 0;
      endfunction

      function void set_channels(input logic [CH_CFG_W-1:0] value);
         chan_cfg = value;
      endfunction

      function int unsigned pending();
         return awaited_rsp.size();
      endfunction

      // Average of the active lanes, half away from zero, clamped to +/-1.0
      function int mix_frame(input frame_type frame);
         int active;
         int total;
         int mag;
         int quot;
         active = int'(chan_cfg);
         if (active == 0) active = 1;
         if (active > MAX_CHANNELS) active = MAX_CHANNELS;
         total = 0;
         for (int c = 0; c < active; c++) begin
            total += $signed(frame[c*SAMPLE_W +: SAMPLE_W]);
         end
         mag  = (total < 0) ? -total : total;
         quot = (mag * 2 + active) / (2 * active);
         if (quot > 32768) quot = 32768;
         return (total < 0) ? -quot : quot;
      endfunction

      function void note_request(input req_code_type code, input frame_type frame);
         mono_rsp_type want;
         int           mixed;
         want = '0;
         case (code)
            REQ_PUSH: begin
               mixed = mix_frame(frame);
               if (held >= RING_DEPTH) begin
                  want.dropped = 1'b1;
               end else begin
                  ring[wr_ptr] = MONO_W'(mixed);
                  wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
                  held++;
               end
            end
            REQ_PULL: begin
               if (held == 0) begin
                  want.underrun = 1'b1;
               end else begin
                  want.mono = ring[rd_ptr];
                  rd_ptr    = (rd_ptr + 1) % RING_DEPTH;
                  held--;
               end
            end
            REQ_FLUSH: begin
               wr_ptr = 0;
               rd_ptr = 0;
               held   = 0;
            end
            default: ;
         endcase
         want.fill = CNT_W'(held);
         awaited_rsp.push_back(want);
      endfunction

      function void check_response(input logic [RSP_TDATA_W-1:0] data,
                                   input logic [1:0] flags);
         mono_rsp_type got;
         mono_rsp_type want;
         got.mono     = data[MONO_W-1:0];
         got.fill     = data[MONO_W +: CNT_W];
         got.underrun = flags[0];
         got.dropped  = flags[1];
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] unexpected response: mono %0d fill %0d", $realtime,
                        $signed(got.mono), got.fill);
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.mono !== want.mono || got.underrun !== want.underrun ||
             got.dropped !== want.dropped || got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"[%0t] mismatch: mono %0d/%0d underrun %0b/%0b ",
                         "dropped %0b/%0b fill %0d/%0d (exp/act)"},
                        $realtime, $signed(want.mono), $signed(got.mono),
                        want.underrun, got.underrun, want.dropped, got.dropped,
                        want.fill, got.fill);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CH_CFG_W-1:0]    csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   frame_type              req_tdata  = '0;    // chan_sample_0..7, 18 bits each
   logic [1:0]             req_tuser  = '0;    // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // mono_out, fill_level, zero pad
   logic [1:0]             rsp_tuser;          // underrun, dropped

   downmix_ring_tracker tracker = new();

   bit          pace_on     = 1'b0;   // random gaps on both streams
   int unsigned stall_left  = 0;
   int unsigned cycle_count = 0;

   always #10 clock = ~clock;

   audio_downmix_ring_fifo u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response-side backpressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (pace_on && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response monitor: values seen here are the ones present at the edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tdata, rsp_tuser);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic frame_type pack_lanes(input int lanes [MAX_CHANNELS]);
      frame_type f;
      f = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) f[c*SAMPLE_W +: SAMPLE_W] = lanes[c][SAMPLE_W-1:0];
      return f;
   endfunction

   function automatic frame_type uniform_frame(input int v);
      int lanes [MAX_CHANNELS];
      foreach (lanes[c]) lanes[c] = v;
      return pack_lanes(lanes);
   endfunction

   // Per-lane mix of full-range, mid-range, rail and near-zero samples
   function automatic frame_type random_frame();
      int lanes [MAX_CHANNELS];
      foreach (lanes[c]) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: lanes[c] = int'($urandom_range(0, 262143)) - 131072;
            4, 5:       lanes[c] = int'($urandom_range(0, 80000)) - 40000;
            6:          lanes[c] = 131071;
            7:          lanes[c] = -131072;
            8:          lanes[c] = int'($urandom_range(0, 16)) - 8;
            default:    lanes[c] = int'($urandom_range(0, 2000)) + 129071;
         endcase
      end
      return pack_lanes(lanes);
   endfunction

   // One request transaction; tvalid is left high for a back-to-back follow-up
   task automatic send_request(input req_code_type code, input frame_type frame);
      int gap;
      gap = pace_on ? (($urandom_range(0, 99) < 40) ? pick_gap() : 0) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= frame;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(code, frame);
   endtask

   // Drop tvalid and wait until every response is back and the pipe is empty
   task automatic settle_ring_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_channel_count(input logic [CH_CFG_W-1:0] value);
      settle_ring_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_channels(value);
   endtask

   task automatic random_burst(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50)      send_request(REQ_PUSH, random_frame());
         else if (r < 88) send_request(REQ_PULL, random_frame());
         else if (r < 94) send_request(REQ_NOP, random_frame());
         else             send_request(REQ_FLUSH, random_frame());
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [CH_CFG_W-1:0] cfg_plan [$];

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value: one channel, other lanes must be ignored
      send_request(REQ_PULL, '0);                                    // empty ring
      send_request(REQ_NOP, random_frame());
      send_request(REQ_PUSH, pack_lanes('{131071, -131072, 1, 0, 0, 0, 0, 0}));
      send_request(REQ_PUSH, pack_lanes('{-131072, 131071, 9, 9, 9, 9, 9, 9}));
      send_request(REQ_PUSH, pack_lanes('{32767, 0, 0, 0, 0, 0, 0, 0}));
      send_request(REQ_PUSH, pack_lanes('{-1, 5, 0, 0, 0, 0, 0, 0}));
      send_request(REQ_NOP, '0);
      repeat (4) send_request(REQ_PULL, '0);
      send_request(REQ_PULL, '0);                                    // underrun again
      send_request(REQ_PUSH, pack_lanes('{100, 0, 0, 0, 0, 0, 0, 0}));
      send_request(REQ_FLUSH, '0);
      send_request(REQ_PULL, '0);                                    // empty after flush

      // all eight lanes: rail clamps and rounding ties
      set_channel_count(CH_CFG_W'(8));
      send_request(REQ_PUSH, uniform_frame(131071));
      send_request(REQ_PUSH, uniform_frame(-131072));
      send_request(REQ_PUSH, pack_lanes('{4, 0, 0, 0, 0, 0, 0, 0}));    // +0.5 -> +1
      send_request(REQ_PUSH, pack_lanes('{-12, 0, 0, 0, 0, 0, 0, 0}));  // -1.5 -> -2
      send_request(REQ_PUSH, pack_lanes('{3, 0, 0, 0, 0, 0, 0, 0}));
      repeat (5) send_request(REQ_PULL, '0);

      // random phases, zero and over-range counts included
      cfg_plan = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd6, 4'd9, 4'd2, 4'd7, 4'd5, 4'd4, 4'd8};
      pace_on = 1'b1;
      foreach (cfg_plan[i]) begin
         set_channel_count(cfg_plan[i]);
         random_burst(40);
      end

      settle_ring_idle();
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/admf_pkg.sv
hw/rtl/admf_lane.sv
hw/rtl/admf_merge.sv
hw/rtl/audio_downmix_ring_fifo.sv
test/tb_audio_downmix_ring_fifo.sv
